// File: design/bisp_pkg.sv
package bisp_pkg;

    // Configuration register indexes
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CFG_MAGIC      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_HEADER_TYPE = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_DATA_TYPE  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_GRAY_CODE  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_RGB_CODE   = 3'd4;

    // Configuration reset values
    localparam logic [15:0] MAGIC_RST       = 16'hCAFE;
    localparam logic [7:0]  HEADER_TYPE_RST = 8'd0;
    localparam logic [7:0]  DATA_TYPE_RST   = 8'd1;
    localparam logic [7:0]  GRAY_CODE_RST   = 8'd0;
    localparam logic [7:0]  RGB_CODE_RST    = 8'd1;

    // Header block length in bytes: width, height, color
    localparam int HDR_BYTES = 9;

    // Output field widths
    localparam int DIM_OUT_W = 13;

    // Final status codes
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_MAGIC  = 3'd1,
        ST_TRUNC  = 3'd2,
        ST_HEADER = 3'd3,
        ST_PIXELS = 3'd4
    } status_t;

    typedef struct packed {
        logic [15:0] magic;
        logic [7:0]  header_type;
        logic [7:0]  data_type;
        logic [7:0]  gray_code;
        logic [7:0]  rgb_code;
    } cfg_t;

    typedef struct packed {
        logic       last_byte;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic                 has_pixel;
        logic [7:0]           pixel_value;
        logic                 has_header;
        logic [DIM_OUT_W-1:0] image_width;
        logic [DIM_OUT_W-1:0] image_height;
        logic                 is_rgb;
        logic                 done_res;
        status_t              status;
    } result_t;

endpackage

// File: design/bisp_in_reg.sv
module bisp_in_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  bisp_pkg::in_item_t s_item,
    input  logic               take,
    output logic               vld,
    output bisp_pkg::in_item_t item
);
    import bisp_pkg::*;

    logic     vld_reg;
    in_item_t item_reg;

    // Space when empty or when the held item moves on this cycle
    assign s_tready = !vld_reg || take;
    assign vld      = vld_reg;
    assign item     = item_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            vld_reg <= s_tvalid;
        end
    end

    // Item payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

// File: design/bisp_parser.sv
module bisp_parser
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  bisp_pkg::in_item_t item,
    input  bisp_pkg::cfg_t     cfg,
    output bisp_pkg::result_t  res,
    output logic               res_vld
);
    import bisp_pkg::*;

    localparam int     DimW   = $clog2(MAX_DIM + 1);
    localparam int     AreaW  = 2 * DimW;
    localparam int     TotW   = AreaW + 2;
    localparam longint MaxPix = longint'(MAX_DIM) * longint'(MAX_DIM) * 3;
    localparam int     PixW   = $clog2(MaxPix + 1);

    typedef enum logic [2:0] {
        PH_MAGIC0,
        PH_MAGIC1,
        PH_TYPE,
        PH_SIZE,
        PH_PAYLOAD,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_BADFIRST,
        KIND_DATA,
        KIND_SKIP
    } kind_t;

    phase_t           phase_reg, phase_next;
    logic [1:0]       fcnt_reg, fcnt_next;
    logic [31:0]      asm_reg, asm_next;
    logic [30:0]      rem_reg, rem_next;
    kind_t            kind_reg, kind_next;
    logic [DimW-1:0]  width_reg, width_next;
    logic [DimW-1:0]  height_reg, height_next;
    logic             rgb_reg, rgb_next;
    logic [AreaW-1:0] area_reg, area_next;
    logic [PixW-1:0]  pcnt_reg, pcnt_next;
    status_t          err_reg, err_next;
    logic             hdr_seen_reg, hdr_seen_next;

    logic [7:0]       b;
    logic             last;
    logic [31:0]      word;
    logic [3:0]       hidx;
    logic [TotW-1:0]  total;
    logic             pix, hdr, blk_end, cnt_eq;
    logic [31:0]      w32, h32;
    status_t          err_fin;
    logic             rgb_fin;

    assign b    = item.byte_value;
    assign last = item.last_byte;

    // Image size in bytes from the latched header
    assign total = TotW'(area_reg) + (rgb_reg ? TotW'({area_reg, 1'b0}) : TotW'(0));

    // Header byte position inside the header block
    assign hidx = 4'(HDR_BYTES) - rem_reg[3:0];

    function automatic logic dim_ok(input logic [31:0] v);
        return !v[31] && (v <= 32'(MAX_DIM));
    endfunction

    // Per-byte parse step
    always_comb
    begin
        phase_next    = phase_reg;
        fcnt_next     = fcnt_reg;
        asm_next      = asm_reg;
        rem_next      = rem_reg;
        kind_next     = kind_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        rgb_next      = rgb_reg;
        area_next     = area_reg;
        pcnt_next     = pcnt_reg;
        err_next      = err_reg;
        hdr_seen_next = hdr_seen_reg;
        pix           = 1'b0;
        hdr           = 1'b0;
        blk_end       = 1'b0;
        word          = '0;
        cnt_eq        = 1'b0;

        unique case (phase_reg)
            PH_MAGIC0:
            begin
                asm_next   = 32'(b);
                phase_next = PH_MAGIC1;
                if (last)
                begin
                    if (err_next == ST_OK) err_next = ST_MAGIC;
                    phase_next = PH_ERROR;
                end
            end
            PH_MAGIC1:
            begin
                if ({b, asm_reg[7:0]} != cfg.magic)
                begin
                    if (err_next == ST_OK) err_next = ST_MAGIC;
                    phase_next = PH_ERROR;
                end
                else
                begin
                    asm_next   = '0;
                    phase_next = PH_TYPE;
                    if (last)
                    begin
                        if (err_next == ST_OK) err_next = ST_TRUNC;
                        phase_next = PH_ERROR;
                    end
                end
            end
            PH_TYPE:
            begin
                if (!hdr_seen_reg)
                    kind_next = (b == cfg.header_type) ? KIND_HEADER : KIND_BADFIRST;
                else
                    kind_next = (b == cfg.data_type) ? KIND_DATA : KIND_SKIP;
                fcnt_next  = '0;
                asm_next   = '0;
                phase_next = PH_SIZE;
                if (last)
                begin
                    if (err_next == ST_OK) err_next = ST_TRUNC;
                    phase_next = PH_ERROR;
                end
            end
            PH_SIZE:
            begin
                word      = asm_reg | (32'(b) << {fcnt_reg, 3'b000});
                asm_next  = word;
                fcnt_next = fcnt_reg + 2'd1;
                if (fcnt_reg != 2'd3)
                begin
                    if (last)
                    begin
                        if (err_next == ST_OK) err_next = ST_TRUNC;
                        phase_next = PH_ERROR;
                    end
                end
                else if (word[31])
                begin
                    if (err_next == ST_OK) err_next = ST_TRUNC;
                    phase_next = PH_ERROR;
                end
                else
                begin
                    rem_next  = word[30:0];
                    fcnt_next = '0;
                    asm_next  = '0;
                    if (kind_reg == KIND_HEADER && word != 32'(HDR_BYTES))
                        kind_next = KIND_BADFIRST;
                    phase_next = PH_PAYLOAD;
                    if (word == '0)
                        blk_end = 1'b1;
                    else if (last)
                    begin
                        if (err_next == ST_OK) err_next = ST_TRUNC;
                        phase_next = PH_ERROR;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (kind_reg == KIND_HEADER)
                begin
                    if (hidx < 4'd8)
                    begin
                        word     = asm_reg | (32'(b) << {hidx[1:0], 3'b000});
                        asm_next = word;
                        if (hidx[1:0] == 2'd3)
                        begin
                            if (!dim_ok(word))
                                kind_next = KIND_BADFIRST;
                            else if (hidx == 4'd3)
                                width_next = word[DimW-1:0];
                            else
                                height_next = word[DimW-1:0];
                            asm_next = '0;
                        end
                    end
                    else
                    begin
                        // Color byte; the gray code wins when both match
                        if (b == cfg.gray_code)
                            rgb_next = 1'b0;
                        else if (b == cfg.rgb_code)
                            rgb_next = 1'b1;
                        else
                            kind_next = KIND_BADFIRST;
                        area_next = AreaW'(width_reg) * AreaW'(height_reg);
                    end
                end
                else if (kind_reg == KIND_DATA)
                begin
                    if (TotW'(pcnt_reg) >= total)
                    begin
                        if (err_next == ST_OK) err_next = ST_PIXELS;
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        pix       = 1'b1;
                        pcnt_next = pcnt_reg + PixW'(1);
                    end
                end
                rem_next = rem_reg - 31'd1;
                if (err_next == ST_OK)
                begin
                    if (rem_next == '0)
                        blk_end = 1'b1;
                    else if (last)
                    begin
                        err_next   = ST_TRUNC;
                        phase_next = PH_ERROR;
                    end
                end
            end
            default:
            begin
                // Error latched: wait for the last byte
            end
        endcase

        // End of a block
        if (blk_end && err_next == ST_OK)
        begin
            phase_next = PH_TYPE;
            if (!hdr_seen_reg)
            begin
                if (kind_next == KIND_HEADER)
                begin
                    hdr_seen_next = 1'b1;
                    hdr           = 1'b1;
                end
                else
                begin
                    err_next   = ST_HEADER;
                    phase_next = PH_ERROR;
                end
            end
        end

        // Pixel count check for the final status; on the header's own byte
        // the product is not registered yet, but no pixel has been seen
        if (hdr)
            cnt_eq = (width_reg == '0) || (height_reg == '0);
        else
            cnt_eq = (TotW'(pcnt_next) == total);

        // Status and color of this byte, before the end-of-file clear
        err_fin = err_next;
        rgb_fin = rgb_next;

        // Back to the start of a file after the last byte
        if (last)
        begin
            phase_next    = PH_MAGIC0;
            fcnt_next     = '0;
            asm_next      = '0;
            rem_next      = '0;
            kind_next     = KIND_HEADER;
            width_next    = '0;
            height_next   = '0;
            rgb_next      = 1'b0;
            area_next     = '0;
            pcnt_next     = '0;
            err_next      = ST_OK;
            hdr_seen_next = 1'b0;
        end
    end

    // Result fields; width and height are already latched when the header ends
    assign w32 = 32'(width_reg);
    assign h32 = 32'(height_reg);

    always_comb
    begin
        res_vld          = last || pix || hdr;
        res.has_pixel    = pix;
        res.pixel_value  = pix ? b : 8'd0;
        res.has_header   = hdr;
        res.image_width  = hdr ? w32[DIM_OUT_W-1:0] : '0;
        res.image_height = hdr ? h32[DIM_OUT_W-1:0] : '0;
        res.is_rgb       = hdr && rgb_fin;
        res.done_res     = last;
        res.status       = ST_OK;
        if (last)
        begin
            if (err_fin != ST_OK)
                res.status = err_fin;
            else
                res.status = cnt_eq ? ST_OK : ST_PIXELS;
        end
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MAGIC0;
            fcnt_reg     <= '0;
            asm_reg      <= '0;
            rem_reg      <= '0;
            kind_reg     <= KIND_HEADER;
            width_reg    <= '0;
            height_reg   <= '0;
            rgb_reg      <= 1'b0;
            area_reg     <= '0;
            pcnt_reg     <= '0;
            err_reg      <= ST_OK;
            hdr_seen_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            fcnt_reg     <= fcnt_next;
            asm_reg      <= asm_next;
            rem_reg      <= rem_next;
            kind_reg     <= kind_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            rgb_reg      <= rgb_next;
            area_reg     <= area_next;
            pcnt_reg     <= pcnt_next;
            err_reg      <= err_next;
            hdr_seen_reg <= hdr_seen_next;
        end
    end

endmodule

// File: design/bisp_out_reg.sv
module bisp_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bisp_pkg::result_t res_in,
    output logic              free,
    output logic              vld,
    input  logic              rdy,
    output bisp_pkg::result_t res_out
);
    import bisp_pkg::*;

    logic    vld_reg;
    result_t res_reg;

    // Slot is free when empty or drained this cycle
    assign free    = !vld_reg || rdy;
    assign vld     = vld_reg;
    assign res_out = res_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (free)
        begin
            vld_reg <= load;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            res_reg <= res_in;
        end
    end

endmodule

// File: design/block_image_stream_parser_unit.sv
// Block image stream parser: takes one file byte per item on the s_ side
// (tlast on the file's final byte) and gives zero or one result item per
// byte on the m_ side: a pixel byte of a data block, the header fields when
// the header block completes, and on the final byte (m_tlast) the file
// status. A byte can be taken every clock cycle; each byte passes an input
// register, the parse logic and a result register. Flow stops only while
// the result register holds an item that m_tready has not taken. Write the
// cfg registers only while the block is idle.
module block_image_stream_parser_unit
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic [bisp_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [bisp_pkg::CfgDataW-1:0]    cfg_data,
    // Byte input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] byte_value
    input  logic                             s_tlast,   // last_byte
    // Result output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [39:0]                      m_tdata,   // [7:0] pixel_value,
                                                        // [20:8] image_width,
                                                        // [33:21] image_height,
                                                        // [34] is_rgb,
                                                        // [37:35] status, rest 0
    output logic [1:0]                       m_tuser,   // [0] has_pixel,
                                                        // [1] has_header
    output logic                             m_tlast    // done_res
);
    import bisp_pkg::*;

    cfg_t     cfg_reg;
    in_item_t s_item, item;
    logic     in_vld, step, out_free, res_vld;
    result_t  res, out_res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic       <= MAGIC_RST;
            cfg_reg.header_type <= HEADER_TYPE_RST;
            cfg_reg.data_type   <= DATA_TYPE_RST;
            cfg_reg.gray_code   <= GRAY_CODE_RST;
            cfg_reg.rgb_code    <= RGB_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAGIC:       cfg_reg.magic       <= cfg_data;
                CFG_HEADER_TYPE: cfg_reg.header_type <= cfg_data[7:0];
                CFG_DATA_TYPE:   cfg_reg.data_type   <= cfg_data[7:0];
                CFG_GRAY_CODE:   cfg_reg.gray_code   <= cfg_data[7:0];
                CFG_RGB_CODE:    cfg_reg.rgb_code    <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    assign s_item.byte_value = s_tdata;
    assign s_item.last_byte  = s_tlast;

    // A held byte is parsed when the result slot can take its outcome
    assign step = in_vld && out_free;

    bisp_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .take     (step),
        .vld      (in_vld),
        .item     (item)
    );

    bisp_parser #(
        .MAX_DIM (MAX_DIM)
    ) u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .item    (item),
        .cfg     (cfg_reg),
        .res     (res),
        .res_vld (res_vld)
    );

    bisp_out_reg u_out_reg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (step && res_vld),
        .res_in  (res),
        .free    (out_free),
        .vld     (m_tvalid),
        .rdy     (m_tready),
        .res_out (out_res)
    );

    // Output packing
    assign m_tdata = {2'b00, out_res.status, out_res.is_rgb, out_res.image_height,
                      out_res.image_width, out_res.pixel_value};
    assign m_tuser = {out_res.has_header, out_res.has_pixel};
    assign m_tlast = out_res.done_res;

`ifndef SYNTHESIS
    // A pixel byte and header completion never share an item
    a_pix_hdr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_res.has_pixel && out_res.has_header))
        else $error("pixel and header flagged on one item");

    // Status is only carried by the final item
    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_res.done_res) |-> (out_res.status == ST_OK))
        else $error("status set on a non-final item");

    // A reported header never exceeds the dimension limit
    a_hdr_dims: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res.has_header) |->
            (32'(out_res.image_width) <= 32'(MAX_DIM) &&
             32'(out_res.image_height) <= 32'(MAX_DIM)))
        else $error("header dimension above limit");

    // A parsed byte that yields a result lands in the result register
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_vld) |=> m_tvalid)
        else $error("result lost after parse step");
`endif

endmodule
